// ----- design/kpr_pkg.sv -----
// ============================================================================
// Kermit packet receiver package
// Shared constants, controller state encoding and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package kpr_pkg;

    // Receive buffer depth and derived widths.
    localparam int PACKET_BYTES = 32;
    localparam int BUF_AW       = $clog2(PACKET_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);

    // Reply packet geometry.
    localparam int REPLY_BYTES = 6;
    localparam int REP_W       = $clog2(REPLY_BYTES);

    localparam logic [REP_W-1:0] REP_MARK  = REP_W'(0);
    localparam logic [REP_W-1:0] REP_LEN   = REP_W'(1);
    localparam logic [REP_W-1:0] REP_SEQ   = REP_W'(2);
    localparam logic [REP_W-1:0] REP_TYPE  = REP_W'(3);
    localparam logic [REP_W-1:0] REP_CHECK = REP_W'(4);
    localparam logic [REP_W-1:0] REP_END   = REP_W'(5);

    // Protocol characters.
    localparam logic [7:0] CH_ACK     = 8'h59;
    localparam logic [7:0] CH_NAK     = 8'h4E;
    localparam logic [7:0] CH_DATA    = 8'h44;
    localparam logic [7:0] CH_BREAK   = 8'h42;
    localparam logic [7:0] CH_PREFIX  = 8'h23;
    localparam logic [7:0] CH_REPLY_LEN = 8'h23;
    localparam logic [7:0] CH_OFFSET  = 8'h20;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOAD_BASE  = 2'd0;
    localparam logic [1:0] REG_START_MARK = 2'd1;
    localparam logic [1:0] REG_END_MARK   = 2'd2;

    localparam logic [7:0] RST_START_MARK = 8'h01;
    localparam logic [7:0] RST_END_MARK   = 8'h0D;

    typedef enum logic [11:0] {
        S_HUNT     = 12'b0000_0000_0001,
        S_LEN      = 12'b0000_0000_0010,
        S_SEQ      = 12'b0000_0000_0100,
        S_TYPE     = 12'b0000_0000_1000,
        S_DATA     = 12'b0000_0001_0000,
        S_CHK      = 12'b0000_0010_0000,
        S_REPLY    = 12'b0000_0100_0000,
        S_DR_RD    = 12'b0000_1000_0000,
        S_DR_EVAL  = 12'b0001_0000_0000,
        S_FLUSH    = 12'b0010_0000_0000,
        S_DONE     = 12'b0100_0000_0000,
        S_SPARE    = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic start;      // start mark seen, clear packet counters
        logic len;        // length byte
        logic seq;        // sequence byte
        logic typ;        // type byte
        logic data;       // data byte to sum and buffer
        logic chk_rd;     // read the check byte from the buffer
        logic chk;        // evaluate the block check
        logic rep_push;   // push the next reply byte
        logic drain_init; // rewind the buffer read index
        logic dr_rd;      // read the buffer at the drain index
        logic esc_set;    // prefix seen, skip it
        logic dr_push;    // push one decoded memory write
        logic flush;      // release the held result as the last one
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic is_end;
        logic good;
        logic brk;
        logic is_dtype;
        logic rep_last;
        logic drain_done;
        logic is_prefix;
        logic esc;
        logic push_ok;
        logic out_free;
        logic p_valid;
    } t_dp_status;

    // Type-1 block check of an 8-bit sum.
    function automatic logic [7:0] type1_check(input logic [7:0] s);
        logic [7:0] t;
        t = s + {6'd0, s[7:6]};
        return CH_OFFSET + {2'b00, t[5:0]};
    endfunction

endpackage

// ----- design/kpr_ctrl.sv -----
// ============================================================================
// Kermit packet receiver controller
// One-hot state machine that sequences header parsing, the block check, the
// reply packet and the decode of buffered data into memory writes.
// ============================================================================
module kpr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  kpr_pkg::t_dp_status   i_status,
    output kpr_pkg::t_dp_cmd      o_cmd
);

    kpr_pkg::t_state r_state;
    kpr_pkg::t_state n_state;
    logic            w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpr_pkg::S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_stall = !((r_state == kpr_pkg::S_HUNT) || (r_state == kpr_pkg::S_LEN) ||
                    (r_state == kpr_pkg::S_SEQ)  || (r_state == kpr_pkg::S_TYPE) ||
                    (r_state == kpr_pkg::S_DATA) || (r_state == kpr_pkg::S_DONE));
    end

    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            kpr_pkg::S_HUNT: begin
                if (w_accept && i_status.is_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = kpr_pkg::S_LEN;
                end
            end
            kpr_pkg::S_LEN: begin
                if (w_accept) begin
                    o_cmd.len = 1'b1;
                    n_state   = kpr_pkg::S_SEQ;
                end
            end
            kpr_pkg::S_SEQ: begin
                if (w_accept) begin
                    o_cmd.seq = 1'b1;
                    n_state   = kpr_pkg::S_TYPE;
                end
            end
            kpr_pkg::S_TYPE: begin
                if (w_accept) begin
                    o_cmd.typ = 1'b1;
                    n_state   = kpr_pkg::S_DATA;
                end
            end
            kpr_pkg::S_DATA: begin
                if (w_accept) begin
                    if (i_status.is_end) begin
                        o_cmd.chk_rd = 1'b1;
                        n_state      = kpr_pkg::S_CHK;
                    end else begin
                        o_cmd.data = 1'b1;
                    end
                end
            end
            kpr_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = kpr_pkg::S_REPLY;
            end
            kpr_pkg::S_REPLY: begin
                if (i_status.push_ok) begin
                    o_cmd.rep_push = 1'b1;
                    if (i_status.rep_last) begin
                        if (!i_status.brk && i_status.good && i_status.is_dtype) begin
                            o_cmd.drain_init = 1'b1;
                            n_state          = kpr_pkg::S_DR_RD;
                        end else begin
                            n_state = kpr_pkg::S_FLUSH;
                        end
                    end
                end
            end
            kpr_pkg::S_DR_RD: begin
                if (i_status.drain_done) begin
                    n_state = kpr_pkg::S_FLUSH;
                end else begin
                    o_cmd.dr_rd = 1'b1;
                    n_state     = kpr_pkg::S_DR_EVAL;
                end
            end
            kpr_pkg::S_DR_EVAL: begin
                if (!i_status.esc && i_status.is_prefix) begin
                    o_cmd.esc_set = 1'b1;
                    n_state       = kpr_pkg::S_DR_RD;
                end else if (i_status.push_ok) begin
                    o_cmd.dr_push = 1'b1;
                    n_state       = kpr_pkg::S_DR_RD;
                end
            end
            kpr_pkg::S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = i_status.brk ? kpr_pkg::S_DONE : kpr_pkg::S_HUNT;
                end
            end
            kpr_pkg::S_DONE: begin
                n_state = kpr_pkg::S_DONE;
            end
            default: begin
                n_state = kpr_pkg::S_HUNT;
            end
        endcase
    end

endmodule

// ----- design/kpr_datapath.sv -----
// ============================================================================
// Kermit packet receiver datapath
// Running sum, header registers, receive buffer memory, reply byte builder,
// prefix decoder, and the held-result and output registers.
// ============================================================================
module kpr_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kpr_pkg::t_dp_cmd      i_cmd,
    output kpr_pkg::t_dp_status   o_status,
    input  logic [7:0]            i_rx_byte,
    input  logic [31:0]           i_load_base,
    input  logic [7:0]            i_start_mark,
    input  logic [7:0]            i_end_mark,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_kind,
    output logic [7:0]            o_value,
    output logic [31:0]           o_address,
    output logic                  o_last,
    output logic                  o_finished
);

    logic [7:0]                  r_mem [kpr_pkg::PACKET_BYTES];
    logic [7:0]                  r_rdata;
    logic [7:0]                  r_sum;
    logic [5:0]                  r_seq;
    logic [7:0]                  r_type;
    logic [kpr_pkg::CNT_W-1:0]   r_bc;
    logic                        r_ovf;
    logic [31:0]                 r_woff;
    logic                        r_good;
    logic [kpr_pkg::REP_W-1:0]   r_rep_idx;
    logic [kpr_pkg::CNT_W-1:0]   r_idx;
    logic                        r_esc;

    logic                        r_p_valid;
    logic                        r_p_kind;
    logic [7:0]                  r_p_value;
    logic [31:0]                 r_p_addr;

    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [7:0]                  r_out_value;
    logic [31:0]                 r_out_addr;
    logic                        r_out_last;
    logic                        r_out_finished;

    logic [kpr_pkg::CNT_W-1:0]   w_bc_m1;
    logic [kpr_pkg::BUF_AW-1:0]  w_rd_addr;
    logic [7:0]                  w_tseq;
    logic [7:0]                  w_rtype;
    logic [7:0]                  w_rcs;
    logic [7:0]                  w_rep_value;
    logic [7:0]                  w_dec_value;
    logic                        w_brk;
    logic                        w_out_free;
    logic                        w_push;
    logic                        w_move;

    assign w_bc_m1   = r_bc - kpr_pkg::CNT_W'(1);
    assign w_rd_addr = i_cmd.dr_rd ? r_idx[kpr_pkg::BUF_AW-1:0]
                                   : w_bc_m1[kpr_pkg::BUF_AW-1:0];
    assign w_brk     = (r_type == kpr_pkg::CH_BREAK);

    // Receive buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.data && (r_bc < kpr_pkg::CNT_W'(kpr_pkg::PACKET_BYTES))) begin
            r_mem[r_bc[kpr_pkg::BUF_AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.chk_rd || i_cmd.dr_rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Reply byte builder.
    always_comb begin
        w_tseq  = {2'b00, r_seq} + kpr_pkg::CH_OFFSET;
        w_rtype = r_good ? kpr_pkg::CH_ACK : kpr_pkg::CH_NAK;
        w_rcs   = kpr_pkg::type1_check(kpr_pkg::CH_REPLY_LEN + w_tseq + w_rtype);
        case (r_rep_idx)
            kpr_pkg::REP_MARK:  w_rep_value = i_start_mark;
            kpr_pkg::REP_LEN:   w_rep_value = kpr_pkg::CH_REPLY_LEN;
            kpr_pkg::REP_SEQ:   w_rep_value = w_tseq;
            kpr_pkg::REP_TYPE:  w_rep_value = w_rtype;
            kpr_pkg::REP_CHECK: w_rep_value = w_rcs;
            kpr_pkg::REP_END:   w_rep_value = i_end_mark;
            default:            w_rep_value = 8'h00;
        endcase
    end

    // Undo prefix quoting of the character that follows a prefix.
    always_comb begin
        w_dec_value = r_rdata;
        if (r_esc) begin
            if (r_rdata[6:5] == 2'b10) begin
                w_dec_value = r_rdata & 8'hBF;
            end else if ((r_rdata == 8'h3F) || (r_rdata == 8'hBF)) begin
                w_dec_value = r_rdata | 8'h40;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_push     = i_cmd.rep_push || i_cmd.dr_push;
    assign w_move     = (w_push && r_p_valid) || i_cmd.flush;

    always_comb begin
        o_status.is_start   = (i_rx_byte == i_start_mark);
        o_status.is_end     = (i_rx_byte == i_end_mark);
        o_status.good       = r_good;
        o_status.brk        = w_brk;
        o_status.is_dtype   = (r_type == kpr_pkg::CH_DATA);
        o_status.rep_last   = (r_rep_idx == kpr_pkg::REP_END);
        o_status.drain_done = (r_idx >= w_bc_m1);
        o_status.is_prefix  = (r_rdata == kpr_pkg::CH_PREFIX);
        o_status.esc        = r_esc;
        o_status.push_ok    = !r_p_valid || w_out_free;
        o_status.out_free   = w_out_free;
        o_status.p_valid    = r_p_valid;
    end

    // Packet parsing and check state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_seq     <= '0;
            r_type    <= '0;
            r_bc      <= '0;
            r_ovf     <= 1'b0;
            r_woff    <= '0;
            r_good    <= 1'b0;
            r_rep_idx <= '0;
            r_idx     <= '0;
            r_esc     <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_bc  <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.len) begin
                r_sum <= i_rx_byte;
            end
            if (i_cmd.seq) begin
                r_sum <= r_sum + i_rx_byte;
                r_seq <= 6'(i_rx_byte - kpr_pkg::CH_OFFSET);
            end
            if (i_cmd.typ) begin
                r_sum  <= r_sum + i_rx_byte;
                r_type <= i_rx_byte;
            end
            if (i_cmd.data) begin
                r_sum <= r_sum + i_rx_byte;
                if (r_bc < kpr_pkg::CNT_W'(kpr_pkg::PACKET_BYTES)) begin
                    r_bc <= r_bc + kpr_pkg::CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.chk) begin
                r_good    <= (r_bc != '0) && !r_ovf &&
                             (kpr_pkg::type1_check(r_sum - r_rdata) == r_rdata);
                r_rep_idx <= '0;
            end
            if (i_cmd.rep_push) begin
                r_rep_idx <= r_rep_idx + kpr_pkg::REP_W'(1);
            end
            if (i_cmd.drain_init) begin
                r_idx <= '0;
                r_esc <= 1'b0;
            end
            if (i_cmd.esc_set) begin
                r_idx <= r_idx + kpr_pkg::CNT_W'(1);
                r_esc <= 1'b1;
            end
            if (i_cmd.dr_push) begin
                r_idx  <= r_idx + kpr_pkg::CNT_W'(1);
                r_esc  <= 1'b0;
                r_woff <= r_woff + 32'd1;
            end
        end
    end

    // The newest result is held back one push so that the final result of a
    // transaction can be marked once the sequence is known to be over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_p_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_p_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_push) begin
            r_p_kind  <= 1'b0;
            r_p_value <= w_rep_value;
            r_p_addr  <= '0;
        end else if (i_cmd.dr_push) begin
            r_p_kind  <= 1'b1;
            r_p_value <= w_dec_value;
            r_p_addr  <= i_load_base + r_woff;
        end
        if (w_move) begin
            r_out_kind     <= r_p_kind;
            r_out_value    <= r_p_value;
            r_out_addr     <= r_p_addr;
            r_out_last     <= i_cmd.flush;
            r_out_finished <= w_brk;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_value    = r_out_value;
    assign o_address  = r_out_addr;
    assign o_last     = r_out_last;
    assign o_finished = r_out_finished;

endmodule

// ----- design/kermit_packet_receiver_unit.sv -----
// ============================================================================
// Kermit packet receiver
// Receive side of the Kermit protocol with type-1 block check, reply packet
// generation and decoded data writes to memory.
// ============================================================================
// Usage:
// Received serial bytes enter on the input channel (i_valid, o_stall,
// i_rx_byte). Each accepted byte is one transaction. Header and data bytes
// are absorbed in the cycle they are accepted and cause no output. The end
// mark of a packet causes a burst of output transactions on (o_valid,
// i_stall, o_kind, o_value, o_address, o_last, o_finished): six reply bytes
// to transmit, then for a good data packet one memory write per decoded
// byte. o_last marks the final output of the burst, and o_finished is set on
// the reply to a break packet, after which all input is taken and ignored.
// Sequence: after an end mark the block runs the block check, pushes the
// reply bytes, then for a good data packet reads and evaluates each data
// byte before the check (a prefix counts as one), ends the drain and
// releases the held final result.
// o_stall stays high during a burst. When the receiver asserts i_stall the
// output register holds its transaction and the burst waits in place.
// Reset (synchronous, active low) returns the parser to start-mark hunting
// and restores the registers: load_base 0, start_mark 0x01, end_mark 0x0D.
// Registers sit on an APB-style port at byte addresses 0, 4 and 8.
// ============================================================================
module kermit_packet_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_value,
    output logic [31:0] o_address,
    output logic        o_last,
    output logic        o_finished,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]          r_load_base;
    logic [7:0]           r_start_mark;
    logic [7:0]           r_end_mark;
    logic                 w_cfg_wr;
    logic [1:0]           w_cfg_idx;
    kpr_pkg::t_dp_cmd     w_cmd;
    kpr_pkg::t_dp_status  w_status;

    // The configuration port never inserts wait states.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base  <= '0;
            r_start_mark <= kpr_pkg::RST_START_MARK;
            r_end_mark   <= kpr_pkg::RST_END_MARK;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                kpr_pkg::REG_LOAD_BASE:  r_load_base  <= pwdata;
                kpr_pkg::REG_START_MARK: r_start_mark <= pwdata[7:0];
                kpr_pkg::REG_END_MARK:   r_end_mark   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            kpr_pkg::REG_LOAD_BASE:  prdata = r_load_base;
            kpr_pkg::REG_START_MARK: prdata = {24'd0, r_start_mark};
            kpr_pkg::REG_END_MARK:   prdata = {24'd0, r_end_mark};
            default:                 prdata = 32'd0;
        endcase
    end

    // The controller sequences the packet; the datapath holds all payload.
    kpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    kpr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_rx_byte    (i_rx_byte),
        .i_load_base  (r_load_base),
        .i_start_mark (r_start_mark),
        .i_end_mark   (r_end_mark),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_address    (o_address),
        .o_last       (o_last),
        .o_finished   (o_finished)
    );

    // Input is only taken once every result of the previous burst has left
    // the held-result register.
    a_no_held_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !w_status.p_valid)
        else $error("input taken while a result is still held");

    // A break reply carries only transmit bytes.
    a_finished_is_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> !o_kind)
        else $error("memory write marked finished");

    // Transmit bytes carry a zero address.
    a_tx_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_address == 32'd0))
        else $error("transmit byte with nonzero address");

    // A release of the held result always lands in the output register.
    a_flush_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush |=> (o_valid && o_last))
        else $error("final result not presented after release");

endmodule

// ----- bench/kermit_packet_receiver_unit_tb.sv -----
// ============================================================================
// Kermit packet receiver testbench
// Feeds serial bytes to the receiver, predicts every reply byte and memory
// write in the bench itself, and compares each output transaction with the
// oldest predicted one. A short table of hand-written packets comes first,
// then random packets under several register settings, with idle and stall
// bursts on both channels, a long output hold-off and a closing break packet.
// ============================================================================
module kermit_packet_receiver_unit_tb;

    // Idle time before a register write, enough for a full reply and drain.
    localparam int DRAIN_CYCLES   = 100;
    // Cycles the output side is held off in the pressure test.
    localparam int LONG_HOLD      = 400;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int UNTYPED        = -1;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'h0;
    logic [31:0] pwdata    = 32'h0;

    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [7:0]  o_value;
    logic [31:0] o_address;
    logic        o_last;
    logic        o_finished;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    kermit_packet_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_value    (o_value),
        .o_address  (o_address),
        .o_last     (o_last),
        .o_finished (o_finished),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Predicted output transactions, oldest first.
    // ------------------------------------------------------------------------
    typedef struct {
        logic        kind;
        logic [7:0]  value;
        logic [31:0] address;
        logic        last;
        logic        finished;
    } t_rx_result;

    t_rx_result owed_results[$];

    // Bench copy of the register file.
    logic [31:0] cfg_load_base  = 32'h0;
    logic [7:0]  cfg_start_mark = kpr_pkg::RST_START_MARK;
    logic [7:0]  cfg_end_mark   = kpr_pkg::RST_END_MARK;

    // Bench copy of the parser state.
    typedef enum logic [5:0] {
        RX_HUNT = 6'b00_0001,
        RX_LEN  = 6'b00_0010,
        RX_SEQ  = 6'b00_0100,
        RX_TYPE = 6'b00_1000,
        RX_DATA = 6'b01_0000,
        RX_DONE = 6'b10_0000
    } t_rx_phase;

    t_rx_phase   rx_phase     = RX_HUNT;
    logic [7:0]  run_sum      = 8'h00;
    logic [5:0]  rx_seq       = 6'd0;
    logic [7:0]  rx_type      = 8'h00;
    logic [7:0]  pkt_buf [kpr_pkg::PACKET_BYTES];
    int          buf_count    = 0;
    logic        buf_over     = 1'b0;
    logic [31:0] write_offset = 32'h0;

    // What the last accepted byte was predicted to cause.
    int          step_count = 0;
    logic [7:0]  step_reply = 8'h00;

    // Run statistics and control flags shared between processes.
    int unsigned bytes_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned n_ack           = 0;
    int unsigned n_nak           = 0;
    int unsigned n_stores        = 0;
    int unsigned settings_used   = 0;
    int unsigned mismatches      = 0;
    int unsigned quiet_cycles    = 0;
    bit          gaps_on         = 1'b1;
    bit          hold_request    = 1'b0;

    // ------------------------------------------------------------------------
    // Type-1 block check: fold the top two bits of the sum into the low six
    // and make the result printable.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] blk_check(input logic [7:0] s);
        logic [7:0] folded;
        folded = s + (s >> 6);
        return kpr_pkg::CH_OFFSET + (folded & 8'h3F);
    endfunction

    function automatic t_rx_result tx_or_store(input logic k, input logic [7:0] v,
                                               input logic [31:0] a);
        t_rx_result r;
        r.kind     = k;
        r.value    = v;
        r.address  = a;
        r.last     = 1'b0;
        r.finished = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: advances the bench parser by one received byte and appends
    // the transactions it causes to owed_results.
    // ------------------------------------------------------------------------
    function automatic void absorb_rx_byte(input logic [7:0] b);
        t_rx_result burst[$];
        logic       good;
        logic [7:0] chk;
        logic [7:0] tseq;
        logic [7:0] rtype;
        logic [7:0] rsum;
        logic [7:0] c;
        int         vlen;
        int         i;
        step_count = 0;
        step_reply = 8'h00;
        case (rx_phase)
            RX_HUNT: begin
                if (b == cfg_start_mark) begin
                    buf_count = 0;
                    buf_over  = 1'b0;
                    rx_phase  = RX_LEN;
                end
                return;
            end
            RX_LEN: begin
                // The length byte only feeds the sum.
                run_sum  = b;
                rx_phase = RX_SEQ;
                return;
            end
            RX_SEQ: begin
                run_sum  = run_sum + b;
                rx_seq   = 6'(b - kpr_pkg::CH_OFFSET);
                rx_phase = RX_TYPE;
                return;
            end
            RX_TYPE: begin
                run_sum  = run_sum + b;
                rx_type  = b;
                rx_phase = RX_DATA;
                return;
            end
            RX_DONE: begin
                return;
            end
            default: ;
        endcase

        if (b != cfg_end_mark) begin
            // Bytes past the buffer are still summed but spoil the packet.
            run_sum = run_sum + b;
            if (buf_count < kpr_pkg::PACKET_BYTES) begin
                pkt_buf[buf_count] = b;
                buf_count++;
            end else begin
                buf_over = 1'b1;
            end
            return;
        end

        // End mark: the last buffered byte is the received check.
        good = (buf_count > 0) && !buf_over;
        if (good) begin
            chk  = pkt_buf[buf_count - 1];
            good = (blk_check(run_sum - chk) == chk);
        end
        tseq  = kpr_pkg::CH_OFFSET + {2'b00, rx_seq};
        rtype = good ? kpr_pkg::CH_ACK : kpr_pkg::CH_NAK;
        rsum  = kpr_pkg::CH_REPLY_LEN + tseq + rtype;
        burst.push_back(tx_or_store(1'b0, cfg_start_mark, 32'h0));
        burst.push_back(tx_or_store(1'b0, kpr_pkg::CH_REPLY_LEN, 32'h0));
        burst.push_back(tx_or_store(1'b0, tseq, 32'h0));
        burst.push_back(tx_or_store(1'b0, rtype, 32'h0));
        burst.push_back(tx_or_store(1'b0, blk_check(rsum), 32'h0));
        burst.push_back(tx_or_store(1'b0, cfg_end_mark, 32'h0));
        if (good) n_ack++;
        else n_nak++;

        if (rx_type == kpr_pkg::CH_BREAK) begin
            rx_phase = RX_DONE;
        end else begin
            rx_phase = RX_HUNT;
            if (good && rx_type == kpr_pkg::CH_DATA) begin
                vlen = buf_count - 1;
                for (i = 0; i < vlen; i++) begin
                    c = pkt_buf[i];
                    if (c == kpr_pkg::CH_PREFIX) begin
                        // A prefix with nothing after it is dropped.
                        i++;
                        if (i >= vlen) break;
                        c = pkt_buf[i];
                        // Control characters travel with bit 6 set; a quoted
                        // '?' or its high twin stands for DEL.
                        if (c[6:5] == 2'b10) c = c & 8'hBF;
                        else if (c == 8'h3F || c == 8'hBF) c = c | 8'h40;
                    end
                    burst.push_back(tx_or_store(1'b1, c, cfg_load_base + write_offset));
                    write_offset = write_offset + 32'd1;
                    n_stores++;
                end
            end
        end

        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) begin
            if (rx_phase == RX_DONE) burst[k].finished = 1'b1;
            owed_results.push_back(burst[k]);
        end
        step_count = burst.size();
        step_reply = rtype;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, and every one is counted.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Output monitor: each accepted output transaction is compared field by
    // field with the oldest predicted one. Signals are read at the rising
    // edge before any update scheduled at that edge takes effect.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (owed_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected output kind %0b value %h addr %h",
                                        o_kind, o_value, o_address));
            end else begin
                want = owed_results.pop_front();
                if (o_kind !== want.kind || o_value !== want.value ||
                    o_address !== want.address || o_last !== want.last ||
                    o_finished !== want.finished)
                    flag_mismatch($sformatf(
                        "output %0d got k%0b v%h a%h l%0b f%0b, want k%0b v%h a%h l%0b f%0b",
                        results_checked, o_kind, o_value, o_address, o_last, o_finished,
                        want.kind, want.value, want.address, want.last, want.finished));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel moves a transaction
    // and ends the run when the count reaches the limit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d outputs still owed",
                     WATCHDOG_LIMIT, owed_results.size());
            $display("kermit_packet_receiver_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output-side back-pressure. Normally random stall bursts separated by
    // free-running stretches. On request the output is held off for a long
    // stretch, counted here, so that the reply burst backs up into the input
    // channel.
    // ------------------------------------------------------------------------
    initial begin : receiver_stall
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register writes: setup cycle, then access cycle until pready. The bench
    // register copy follows the write. The bus goes idle between writes so
    // that psel is never lowered and raised in the same time step.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            kpr_pkg::REG_LOAD_BASE:  cfg_load_base  = val;
            kpr_pkg::REG_START_MARK: cfg_start_mark = val[7:0];
            kpr_pkg::REG_END_MARK:   cfg_end_mark   = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] base, input logic [7:0] smark,
                                input logic [7:0] emark);
        apb_write(kpr_pkg::REG_LOAD_BASE, base);
        apb_write(kpr_pkg::REG_START_MARK, {24'h0, smark});
        apb_write(kpr_pkg::REG_END_MARK, {24'h0, emark});
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver. An optional idle burst comes first; valid then stays high
    // until the transaction is taken, and is only lowered by the next idle
    // burst or when the sender stops.
    // ------------------------------------------------------------------------
    task automatic offer_rx_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        absorb_rx_byte(b);
        bytes_sent++;
    endtask

    // Stops the sender and waits until every predicted output has arrived,
    // then lets the block run out any work that causes no output.
    task automatic settle();
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] x);
        logic [7:0] v;
        do v = 8'($urandom); while (v == x);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // One packet with random content. n_data counts the buffered bytes before
    // the check; a negative n_data sends an empty packet (end mark right
    // after the type byte). A few noise bytes may precede the start mark.
    // ------------------------------------------------------------------------
    task automatic send_packet(input logic [7:0] ptype, input int n_data,
                               input bit spoil, input bit quoting);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] chk;
        repeat ($urandom_range(0, 2)) offer_rx_byte(byte_other_than(cfg_start_mark));
        // Mostly sensible length and sequence bytes, sometimes anything.
        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                       : 8'(35 + ((n_data > 0) ? n_data : 0)));
        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                       : 8'(32 + $urandom_range(0, 63)));
        body.push_back(ptype);
        while (int'(body.size()) < n_data + 3) begin
            if (quoting && n_data + 3 - int'(body.size()) >= 2 &&
                $urandom_range(0, 3) == 0) begin
                body.push_back(kpr_pkg::CH_PREFIX);
                body.push_back(byte_other_than(cfg_end_mark));
            end else begin
                body.push_back(byte_other_than(cfg_end_mark));
            end
        end
        // Now and then a lone prefix just before the check.
        if (quoting && n_data > 0 && $urandom_range(0, 5) == 0)
            body[body.size() - 1] = kpr_pkg::CH_PREFIX;
        sum = 8'h00;
        foreach (body[k]) sum = sum + body[k];
        if (n_data >= 0) begin
            chk = blk_check(sum);
            if (spoil) chk = chk ^ 8'($urandom_range(1, 63));
            body.push_back(chk);
        end
        offer_rx_byte(cfg_start_mark);
        foreach (body[k]) offer_rx_byte(body[k]);
        offer_rx_byte(cfg_end_mark);
    endtask

    // Mostly data packets, some other types, some empty or with a bad check.
    task automatic random_packets(input int unsigned target);
        int unsigned base_count;
        int          pick;
        int          n;
        logic [7:0]  ptype;
        base_count = bytes_sent;
        while (bytes_sent - base_count < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) ptype = kpr_pkg::CH_DATA;
            else if (pick == 6) ptype = kpr_pkg::CH_ACK;
            else if (pick == 7) ptype = kpr_pkg::CH_NAK;
            else ptype = byte_other_than(kpr_pkg::CH_BREAK);
            n = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 8);
            send_packet(ptype, n, $urandom_range(0, 5) == 0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table, sent with the reset marks (start 0x01, end 0x0D).
    // n_res and reply are typed in where they are obvious; UNTYPED rows rely
    // on the predictor alone. Typed rows are checked against the predictor.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [7:0] rx;
        int         n_res;
        logic [7:0] reply;
    } t_dir_row;

    t_dir_row dir_rows [26] = '{
        // Noise while hunting, both extremes.
        '{8'h00, 0, 8'h00},
        '{8'hFF, 0, 8'h00},
        // Header bytes equal to the marks are taken as header bytes, and an
        // end mark right after the type byte gives an empty packet: NAK.
        '{8'h01, 0, 8'h00},
        '{8'h0D, 0, 8'h00},
        '{8'h01, 0, 8'h00},
        '{kpr_pkg::CH_NAK, 0, 8'h00},
        '{8'h0D, 6, kpr_pkg::CH_NAK},
        // Good data packet with two quoted characters: ACK and three writes
        // just below the top of memory.
        '{8'h01, 0, 8'h00},
        '{8'h27, UNTYPED, 8'h00},
        '{8'h20, UNTYPED, 8'h00},
        '{kpr_pkg::CH_DATA, 0, 8'h00},
        '{kpr_pkg::CH_PREFIX, UNTYPED, 8'h00},
        '{8'h4D, UNTYPED, 8'h00},
        '{kpr_pkg::CH_PREFIX, UNTYPED, 8'h00},
        '{8'h3F, UNTYPED, 8'h00},
        '{8'h41, UNTYPED, 8'h00},
        '{8'h40, UNTYPED, 8'h00},
        '{8'h0D, 9, kpr_pkg::CH_ACK},
        // Good data packet ending in a lone prefix, which is dropped.
        '{8'h01, 0, 8'h00},
        '{8'h24, UNTYPED, 8'h00},
        '{8'h3F, UNTYPED, 8'h00},
        '{kpr_pkg::CH_DATA, 0, 8'h00},
        '{8'h5A, UNTYPED, 8'h00},
        '{kpr_pkg::CH_PREFIX, UNTYPED, 8'h00},
        '{8'h44, UNTYPED, 8'h00},
        '{8'h0D, 7, kpr_pkg::CH_ACK}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset marks, with a load base near the top of memory.
        program_regs(32'hFFFF_FFFC, kpr_pkg::RST_START_MARK, kpr_pkg::RST_END_MARK);
        foreach (dir_rows[k]) begin
            offer_rx_byte(dir_rows[k].rx);
            if (dir_rows[k].n_res != UNTYPED &&
                (step_count != dir_rows[k].n_res ||
                 (step_count != 0 && step_reply != dir_rows[k].reply)))
                flag_mismatch($sformatf("table row %0d predicts %0d outputs, reply %h",
                                        k, step_count, step_reply));
        end
        settle();

        // Extreme marks and base; the packet overflows the buffer.
        program_regs(32'h0000_0000, 8'h00, 8'hFF);
        send_packet(kpr_pkg::CH_DATA, kpr_pkg::PACKET_BYTES, 1'b0, 1'b1);
        settle();

        // Opposite extremes, so the write address wraps. The output is held
        // off for a long stretch while the sender keeps going; a full-buffer
        // packet gives the longest burst and the block backs up into its input.
        program_regs(32'hFFFF_FFFF, 8'hFF, 8'h00);
        hold_request = 1'b1;
        send_packet(kpr_pkg::CH_DATA, kpr_pkg::PACKET_BYTES - 1, 1'b0, 1'b0);
        random_packets(4);
        settle();

        // Last part without idling on either side, under random settings,
        // ended by a break packet. Bytes after the break, marks included,
        // must be ignored.
        gaps_on = 1'b0;
        program_regs($urandom, 8'($urandom), 8'($urandom));
        if (cfg_end_mark == cfg_start_mark)
            apb_write(kpr_pkg::REG_END_MARK, {24'h0, byte_other_than(cfg_start_mark)});
        random_packets(12);
        send_packet(kpr_pkg::CH_BREAK, $urandom_range(0, 5) - 1,
                    $urandom_range(0, 2) == 0, 1'b1);
        offer_rx_byte(cfg_start_mark);
        offer_rx_byte(8'h23);
        offer_rx_byte(8'h20);
        offer_rx_byte(kpr_pkg::CH_DATA);
        offer_rx_byte(cfg_end_mark);
        settle();

        $display("Covered %0d received bytes, %0d outputs checked: %0d ACK and %0d NAK replies,",
                 bytes_sent, results_checked, n_ack, n_nak);
        $display("%0d memory writes, %0d register settings, overflow, quoting and break packet.",
                 n_stores, settings_used);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("kermit_packet_receiver_unit: match");
        end else begin
            $display("kermit_packet_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/kpr_pkg.sv
design/kpr_ctrl.sv
design/kpr_datapath.sv
design/kermit_packet_receiver_unit.sv
bench/kermit_packet_receiver_unit_tb.sv
